// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros included by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/sbvr_pkg.sv -----
// ----------------------------------------------------------------------------
// sbvr_pkg
// Types, constants and helpers of the braking velocity ramp.
// ----------------------------------------------------------------------------
`default_nettype none

package sbvr_pkg;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_ACCEL_UPPER = 2'd0,
        REG_ACCEL_LOWER = 2'd1,
        REG_SPEED_UPPER = 2'd2,
        REG_SPEED_LOWER = 2'd3
    } t_reg_index;

    localparam int unsigned DATA_W    = 32;
    localparam int unsigned DT_W      = 24;
    localparam int unsigned IN_W      = 3 * DATA_W + DT_W;
    localparam int unsigned ROOT_W    = 32;
    localparam int unsigned REM_W     = ROOT_W + 2;
    localparam int unsigned RAD_W     = 2 * ROOT_W;
    localparam int unsigned GAIN_W    = 16;

    // 0.8 in Q0.16.
    localparam logic [GAIN_W-1:0] BRAKE_GAIN = 16'd52429;

    // Square root: four result bits per pipeline stage.
    localparam int unsigned SQRT_STEPS  = 4;
    localparam int unsigned SQRT_STAGES = ROOT_W / SQRT_STEPS;

    localparam logic signed [DATA_W-1:0] S32_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] S32_MIN = 32'sh8000_0000;

    // Values that travel alongside the square root.
    typedef struct packed {
        logic                     neg;
        logic signed [DATA_W-1:0] vmin;
        logic signed [DATA_W-1:0] vmax;
    } t_side;

    // Saturates a 34-bit signed value to 32 bits.
    function automatic logic signed [DATA_W-1:0] sat34(input logic signed [33:0] x);
        logic signed [DATA_W-1:0] res;
        if (x[33] == x[32] && x[32] == x[31]) begin
            res = x[31:0];
        end else if (x[33]) begin
            res = S32_MIN;
        end else begin
            res = S32_MAX;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/sqrt_braking_velocity_ramp.sv -----
// ----------------------------------------------------------------------------
// sqrt_braking_velocity_ramp
// Velocity command for one joint: square-root braking profile clamped by
// acceleration ramps and speed limits, in a fully pipelined datapath.
// ----------------------------------------------------------------------------
// Usage:
// Items arrive on the s_axis channel, one per cycle at most, each carrying
// the goal position, the current position, the current velocity and the
// time step. Every accepted item yields exactly one velocity command on the
// m_axis channel, in order. The four limit registers are written through
// the plain write port (i_cfg_we, i_cfg_index, i_cfg_data) while the block
// is idle; a write takes effect at the clock edge where i_cfg_we is high.
// From the accepting edge to m_axis_tvalid an item passes twelve register
// stages: two for the distance, ramp products and braking product, eight
// for the square root (four root bits per stage), one for the 0.8 gain and
// one output register. Throughput is one item per cycle while m_axis_tready
// stays high, set by the square root pipeline.
// Each stage has its own valid bit and advances whenever it is empty or the
// stage after it advances, so a stalled receiver only stops the filled
// stages behind the output; bubbles are squeezed out and s_axis_tready stays
// high until all twelve stages hold an item. Nothing is lost or repeated.
// The synchronous active-low reset empties the pipeline and clears the
// limit registers to zero.
// ----------------------------------------------------------------------------
`default_nettype none

module sqrt_braking_velocity_ramp #(
    parameter int unsigned FRACTION_BITS = 16
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Configuration write port.
    input  wire logic                         i_cfg_we,
    input  wire sbvr_pkg::t_reg_index         i_cfg_index,
    input  wire logic [sbvr_pkg::DATA_W-1:0]  i_cfg_data,
    // Input items.
    input  wire logic                         s_axis_tvalid,
    output      logic                         s_axis_tready,
    // [31:0] goal_position, [63:32] current_position,
    // [95:64] current_velocity, [119:96] time_step
    input  wire logic [sbvr_pkg::IN_W-1:0]    s_axis_tdata,
    // Result items.
    output      logic                         m_axis_tvalid,
    input  wire logic                         m_axis_tready,
    // [31:0] velocity_command
    output      logic [sbvr_pkg::DATA_W-1:0]  m_axis_tdata
);
    import sbvr_pkg::*;

`include "assert_macros.svh"

    // Deadband of 0.01 in the position format, rounded.
    localparam logic [DATA_W-1:0] DEADBAND =
        32'(((64'd1 << FRACTION_BITS) + 64'd50) / 64'd100);

    // Stage map.
    localparam int unsigned ST_P1   = 0;
    localparam int unsigned ST_P2   = 1;
    localparam int unsigned ST_SQ0  = 2;
    localparam int unsigned ST_GAIN = ST_SQ0 + SQRT_STAGES;
    localparam int unsigned ST_OUT  = ST_GAIN + 1;
    localparam int unsigned NST     = ST_OUT + 1;

    localparam int unsigned MUL_W  = DATA_W + DT_W + 1;
    localparam int unsigned TERM_W = MUL_W - DT_W;

    // ------------------------------------------------------------------
    // Configuration registers.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] r_accel_upper;
    logic signed [DATA_W-1:0] r_accel_lower;
    logic signed [DATA_W-1:0] r_speed_upper;
    logic signed [DATA_W-1:0] r_speed_lower;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accel_upper <= '0;
            r_accel_lower <= '0;
            r_speed_upper <= '0;
            r_speed_lower <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ACCEL_UPPER: r_accel_upper <= i_cfg_data;
                REG_ACCEL_LOWER: r_accel_lower <= i_cfg_data;
                REG_SPEED_UPPER: r_speed_upper <= i_cfg_data;
                REG_SPEED_LOWER: r_speed_lower <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Valid bits and per-stage advance. A stage loads when it is empty or
    // when the stage after it moves on.
    // ------------------------------------------------------------------
    logic [NST-1:0] r_vld;
    logic [NST-1:0] stage_en;

    always_comb begin
        stage_en[NST-1] = !r_vld[NST-1] || m_axis_tready;
        for (int k = NST - 2; k >= 0; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (stage_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NST; k++) begin
                if (stage_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign s_axis_tready = stage_en[ST_P1];

    // ------------------------------------------------------------------
    // Stage P1: saturated distance with deadband, ramp products.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] in_goal;
    logic signed [DATA_W-1:0] in_pos;
    logic signed [DATA_W-1:0] in_vel;
    logic        [DT_W-1:0]   in_dt;

    assign in_goal = s_axis_tdata[DATA_W-1:0];
    assign in_pos  = s_axis_tdata[2*DATA_W-1:DATA_W];
    assign in_vel  = s_axis_tdata[3*DATA_W-1:2*DATA_W];
    assign in_dt   = s_axis_tdata[IN_W-1:3*DATA_W];

    logic signed [DATA_W:0]   diff;
    logic signed [DATA_W-1:0] dist_sat;
    logic        [DATA_W-1:0] n_p1_dmag;
    logic                     n_p1_neg;

    always_comb begin
        diff = {in_goal[DATA_W-1], in_goal} - {in_pos[DATA_W-1], in_pos};
        if (diff[DATA_W] != diff[DATA_W-1]) begin
            dist_sat = diff[DATA_W] ? S32_MIN : S32_MAX;
        end else begin
            dist_sat = diff[DATA_W-1:0];
        end
        n_p1_neg  = dist_sat[DATA_W-1];
        n_p1_dmag = n_p1_neg ? (~dist_sat + 32'd1) : dist_sat;
        if (n_p1_dmag < DEADBAND) begin
            n_p1_dmag = '0;
            n_p1_neg  = 1'b0;
        end
    end

    logic        [DATA_W-1:0] r_p1_dmag;
    logic                     r_p1_neg;
    logic signed [DATA_W-1:0] r_p1_vel;
    logic signed [MUL_W-1:0]  r_p1_mul_lo;
    logic signed [MUL_W-1:0]  r_p1_mul_hi;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_P1]) begin
            r_p1_dmag   <= n_p1_dmag;
            r_p1_neg    <= n_p1_neg;
            r_p1_vel    <= in_vel;
            r_p1_mul_lo <= MUL_W'(r_accel_lower) * MUL_W'($signed({1'b0, in_dt}));
            r_p1_mul_hi <= MUL_W'(r_accel_upper) * MUL_W'($signed({1'b0, in_dt}));
        end
    end

    // ------------------------------------------------------------------
    // Stage P2: braking product |distance * accel_upper|, rounded ramps.
    // Rounding adds one half and shifts arithmetically, which rounds
    // halves toward positive infinity.
    // ------------------------------------------------------------------
    logic        [DATA_W-1:0] amag;
    logic signed [MUL_W-1:0]  rnd_lo;
    logic signed [MUL_W-1:0]  rnd_hi;

    assign amag   = r_accel_upper[DATA_W-1] ? (~r_accel_upper + 32'd1) : r_accel_upper;
    assign rnd_lo = r_p1_mul_lo + (MUL_W'(1) <<< (DT_W - 1));
    assign rnd_hi = r_p1_mul_hi + (MUL_W'(1) <<< (DT_W - 1));

    logic        [RAD_W-1:0]  r_p2_prod;
    logic                     r_p2_neg;
    logic signed [DATA_W-1:0] r_p2_vel;
    logic signed [TERM_W-1:0] r_p2_term_lo;
    logic signed [TERM_W-1:0] r_p2_term_hi;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_P2]) begin
            r_p2_prod    <= RAD_W'(r_p1_dmag) * RAD_W'(amag);
            r_p2_neg     <= r_p1_neg;
            r_p2_vel     <= r_p1_vel;
            r_p2_term_lo <= rnd_lo[MUL_W-1:DT_W];
            r_p2_term_hi <= rnd_hi[MUL_W-1:DT_W];
        end
    end

    // ------------------------------------------------------------------
    // Ramp bounds, formed as the items enter the square root.
    // ------------------------------------------------------------------
    t_side side_in;

    always_comb begin
        logic signed [DATA_W-1:0] lo;
        logic signed [DATA_W-1:0] hi;
        lo = sat34({{2{r_p2_vel[DATA_W-1]}}, r_p2_vel} + 34'(r_p2_term_lo));
        hi = sat34({{2{r_p2_vel[DATA_W-1]}}, r_p2_vel} + 34'(r_p2_term_hi));
        side_in.neg  = r_p2_neg;
        side_in.vmin = (r_speed_lower > lo) ? r_speed_lower : lo;
        side_in.vmax = (r_speed_upper < hi) ? r_speed_upper : hi;
    end

    // ------------------------------------------------------------------
    // Square root of 2*product, two radicand bits per step, four steps
    // per stage.
    // ------------------------------------------------------------------
    logic [RAD_W-1:0]  r_sq_rad  [SQRT_STAGES];
    logic [REM_W-1:0]  r_sq_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] r_sq_root [SQRT_STAGES];
    t_side             r_sq_side [SQRT_STAGES];

    logic [RAD_W-1:0]  n_sq_rad  [SQRT_STAGES];
    logic [REM_W-1:0]  n_sq_rem  [SQRT_STAGES];
    logic [ROOT_W-1:0] n_sq_root [SQRT_STAGES];

    always_comb begin
        for (int j = 0; j < SQRT_STAGES; j++) begin
            logic [RAD_W-1:0]  rad;
            logic [REM_W-1:0]  rem;
            logic [ROOT_W-1:0] root;
            logic [REM_W-1:0]  trial;
            if (j == 0) begin
                rad  = {r_p2_prod[RAD_W-2:0], 1'b0};
                rem  = '0;
                root = '0;
            end else begin
                rad  = r_sq_rad[j-1];
                rem  = r_sq_rem[j-1];
                root = r_sq_root[j-1];
            end
            for (int s = 0; s < SQRT_STEPS; s++) begin
                rem   = {rem[REM_W-3:0], rad[RAD_W-1:RAD_W-2]};
                rad   = {rad[RAD_W-3:0], 2'b00};
                trial = {root, 2'b01};
                if (rem >= trial) begin
                    rem  = rem - trial;
                    root = {root[ROOT_W-2:0], 1'b1};
                end else begin
                    root = {root[ROOT_W-2:0], 1'b0};
                end
            end
            n_sq_rad[j]  = rad;
            n_sq_rem[j]  = rem;
            n_sq_root[j] = root;
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < SQRT_STAGES; j++) begin
            if (stage_en[ST_SQ0 + j]) begin
                r_sq_rad[j]  <= n_sq_rad[j];
                r_sq_rem[j]  <= n_sq_rem[j];
                r_sq_root[j] <= n_sq_root[j];
                r_sq_side[j] <= (j == 0) ? side_in : r_sq_side[j-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Gain stage: magnitude = round(root * 0.8).
    // ------------------------------------------------------------------
    logic [ROOT_W+GAIN_W-1:0] gain_prod;

    assign gain_prod = (ROOT_W+GAIN_W)'(r_sq_root[SQRT_STAGES-1])
                     * (ROOT_W+GAIN_W)'(BRAKE_GAIN)
                     + (48'd1 << (GAIN_W - 1));

    logic [DATA_W-1:0] r_g_mag;
    t_side             r_g_side;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_GAIN]) begin
            r_g_mag  <= gain_prod[ROOT_W+GAIN_W-1:GAIN_W];
            r_g_side <= r_sq_side[SQRT_STAGES-1];
        end
    end

    // ------------------------------------------------------------------
    // Output stage: signed braking velocity, then the clamp. The upper
    // bound is applied last so that it wins when the bounds cross.
    // ------------------------------------------------------------------
    logic signed [DATA_W-1:0] brake;
    logic signed [DATA_W-1:0] n_out;

    always_comb begin
        if (r_g_side.neg) begin
            brake = (r_g_mag > 32'h8000_0000) ? S32_MIN : (~r_g_mag + 32'd1);
        end else begin
            brake = r_g_mag[DATA_W-1] ? S32_MAX : r_g_mag;
        end
        n_out = (brake > r_g_side.vmin) ? brake : r_g_side.vmin;
        if (r_g_side.vmax < n_out) begin
            n_out = r_g_side.vmax;
        end
    end

    logic [DATA_W-1:0] r_out;

    always_ff @(posedge i_clk) begin
        if (stage_en[ST_OUT]) begin
            r_out <= n_out;
        end
    end

    assign m_axis_tvalid = r_vld[ST_OUT];
    assign m_axis_tdata  = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    // Input back-pressure only once every stage holds an item.
    `ASSERT_IMPLIES(a_ready_full, i_clk, i_rst_n, !s_axis_tready, &r_vld)
    // A nonzero distance magnitude is never inside the deadband.
    `ASSERT_IMPLIES(a_deadband, i_clk, i_rst_n,
                    r_vld[ST_P1] && r_p1_dmag != '0, r_p1_dmag >= DEADBAND)
    // The root remainder never exceeds twice the partial root.
    `ASSERT_IMPLIES(a_sqrt_rem, i_clk, i_rst_n, r_vld[ST_GAIN - 1],
                    r_sq_rem[SQRT_STAGES-1] <= {1'b0, r_sq_root[SQRT_STAGES-1], 1'b0})
    // A loaded command never exceeds its upper bound.
    `ASSERT_NEXT(a_upper_bound, i_clk, i_rst_n, stage_en[ST_OUT] && r_vld[ST_GAIN],
                 $signed(m_axis_tdata) <= $past(r_g_side.vmax))

endmodule

`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb: self-checking bench for sqrt_braking_velocity_ramp
// Streams motion items through the block under several limit settings and
// checks every velocity command against a bit-exact fixed-point predictor.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sbvr_pkg::*;

    localparam int unsigned FRACTION_BITS = 16;
    // Distances below one hundredth of a unit count as already at the goal.
    localparam longint DEADBAND = ((longint'(1) << FRACTION_BITS) + 50) / 100;
    localparam int unsigned LIMIT_CYCLES = 200000;
    localparam int unsigned IDLE_PERCENT = 36;

    // One input item. Packed from the top down so that goal_position lands
    // in the lowest bits of tdata, matching the port layout.
    typedef struct packed {
        logic [DT_W-1:0]          time_step;
        logic signed [DATA_W-1:0] current_velocity;
        logic signed [DATA_W-1:0] current_position;
        logic signed [DATA_W-1:0] goal_position;
    } motion_t;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_we = 1'b0;
    t_reg_index          i_cfg_index = REG_ACCEL_UPPER;
    logic [DATA_W-1:0]   i_cfg_data = '0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    // [31:0] goal_position, [63:32] current_position,
    // [95:64] current_velocity, [119:96] time_step
    motion_t             s_axis_tdata = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    // [31:0] velocity_command
    logic [DATA_W-1:0]   m_axis_tdata;

    // Copy of the limit registers as the block should hold them.
    logic signed [DATA_W-1:0] accel_upper_q = '0;
    logic signed [DATA_W-1:0] accel_lower_q = '0;
    logic signed [DATA_W-1:0] speed_upper_q = '0;
    logic signed [DATA_W-1:0] speed_lower_q = '0;

    motion_t                  motions_pending[$];
    logic signed [DATA_W-1:0] expected_commands[$];
    logic signed [DATA_W-1:0] wanted_command;
    int unsigned              mismatches = 0;
    int unsigned              cycle_count = 0;
    // While set, neither side inserts gaps, so the pipeline runs full.
    bit                       steady = 1'b0;

    sqrt_braking_velocity_ramp #(
        .FRACTION_BITS(FRACTION_BITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------

    // Saturates a wide signed value to the 32-bit range.
    function automatic logic signed [DATA_W-1:0] clip32(input longint x);
        logic signed [DATA_W-1:0] res;
        if (x > S32_MAX) begin
            res = S32_MAX;
        end else if (x < S32_MIN) begin
            res = S32_MIN;
        end else begin
            res = x[DATA_W-1:0];
        end
        return res;
    endfunction

    // Velocity reachable in one time step: v + accel*dt, where the product is
    // scaled back by 2^24 with halves rounded toward plus infinity. Adding
    // half an LSB and shifting arithmetically gives exactly that rounding for
    // both signs.
    function automatic logic signed [DATA_W-1:0] ramp_limit(
        input logic signed [DATA_W-1:0] vel,
        input logic signed [DATA_W-1:0] accel,
        input logic [DT_W-1:0]          dt
    );
        longint scaled;
        scaled = longint'(accel) * longint'({40'd0, dt}) + (longint'(1) <<< (DT_W - 1));
        return clip32(longint'(vel) + (scaled >>> DT_W));
    endfunction

    function automatic logic signed [DATA_W-1:0] expected_command(input motion_t m);
        longint                   dist_sat;
        bit [63:0]                dmag;
        bit [63:0]                amag;
        bit [63:0]                radicand;
        bit [63:0]                root;
        bit [63:0]                trial;
        bit [63:0]                gain_mag;
        logic signed [DATA_W-1:0] brake;
        logic signed [DATA_W-1:0] vmin;
        logic signed [DATA_W-1:0] vmax;
        logic signed [DATA_W-1:0] cmd;

        dist_sat = longint'(clip32(longint'(m.goal_position)
                                   - longint'(m.current_position)));
        dmag = (dist_sat < 0) ? -dist_sat : dist_sat;
        if (dmag < DEADBAND) begin
            dist_sat = 0;
            dmag = 0;
        end
        amag = (accel_upper_q < 0) ? -longint'(accel_upper_q) : longint'(accel_upper_q);
        // At most 2 * 2^31 * 2^31 = 2^63, so 64 unsigned bits hold it.
        radicand = 2 * dmag * amag;

        // Floor square root, one result bit at a time from the top.
        root = 0;
        for (int b = 31; b >= 0; b--) begin
            trial = root | (64'd1 << b);
            if (trial * trial <= radicand) begin
                root = trial;
            end
        end

        // Scale by 0.8 in Q0.16 with round half up.
        gain_mag = (root * 64'd52429 + 64'd32768) >> 16;
        brake = clip32((dist_sat < 0) ? -longint'(gain_mag) : longint'(gain_mag));

        vmin = ramp_limit(m.current_velocity, accel_lower_q, m.time_step);
        if (speed_lower_q > vmin) begin
            vmin = speed_lower_q;
        end
        vmax = ramp_limit(m.current_velocity, accel_upper_q, m.time_step);
        if (speed_upper_q < vmax) begin
            vmax = speed_upper_q;
        end

        // The ceiling is applied last, so it wins when the bounds cross.
        cmd = (brake > vmin) ? brake : vmin;
        if (vmax < cmd) begin
            cmd = vmax;
        end
        return cmd;
    endfunction

    // ------------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------------

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Driver: presents pending items, holds each until it is accepted and
    // records the expected command at the accepting edge.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_commands.push_back(expected_command(s_axis_tdata));
            end
            // A held item stays put; otherwise load the next one or idle.
            if (!s_axis_tvalid || s_axis_tready) begin
                if (motions_pending.size() != 0
                        && (steady || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= motions_pending.pop_front();
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor: compares each accepted command with the oldest expectation and
    // stalls the result side at random.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (expected_commands.size() == 0) begin
                    report_mismatch($sformatf("velocity_command %h with no item outstanding",
                                              m_axis_tdata));
                end else begin
                    wanted_command = expected_commands.pop_front();
                    if (m_axis_tdata !== wanted_command) begin
                        report_mismatch($sformatf("velocity_command got %h want %h",
                                                  m_axis_tdata, wanted_command));
                    end
                end
            end
            m_axis_tready <= steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
        end
    end

    // Watchdog against a hung handshake.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("[sqrt_braking_velocity_ramp] ERROR");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------

    task automatic queue_item(
        input logic signed [DATA_W-1:0] goal,
        input logic signed [DATA_W-1:0] pos,
        input logic signed [DATA_W-1:0] vel,
        input logic [DT_W-1:0]          dt
    );
        motion_t m;
        m.goal_position    = goal;
        m.current_position = pos;
        m.current_velocity = vel;
        m.time_step        = dt;
        motions_pending.push_back(m);
    endtask

    // Mostly realistic motions: the goal sits a chosen distance from the
    // current position (near the deadband edge, short, long or exactly on
    // target), often with modest velocities and short control periods. The
    // rest is raw noise over the whole range of every field.
    task automatic queue_random(input int count);
        motion_t m;
        int      offset;
        repeat (count) begin
            m.goal_position    = $urandom;
            m.current_position = $urandom;
            m.current_velocity = $urandom;
            m.time_step        = DT_W'($urandom);
            if ($urandom_range(0, 99) >= 15) begin
                case ($urandom_range(0, 3))
                    0: offset = $urandom_range(600, 710);
                    1: offset = $urandom_range(0, 1 << 20);
                    2: offset = $urandom_range(0, 1 << 27);
                    default: offset = 0;
                endcase
                if ($urandom_range(0, 1)) begin
                    offset = -offset;
                end
                m.goal_position = m.current_position + offset;
                if ($urandom_range(0, 1)) begin
                    m.current_velocity = $urandom_range(0, 1 << 20) - (1 << 19);
                end
                if ($urandom_range(0, 1)) begin
                    m.time_step = DT_W'($urandom_range(0, 1 << 16));
                end
            end
            motions_pending.push_back(m);
        end
    endtask

    // Either any 32-bit pattern or a plausible limit of either sign.
    function automatic logic signed [DATA_W-1:0] random_limit();
        int mag;
        if ($urandom_range(0, 99) < 40) begin
            return $urandom;
        end
        mag = $urandom_range(0, 1 << 22);
        return $urandom_range(0, 1) ? mag : -mag;
    endfunction

    task automatic write_limit(input t_reg_index idx, input logic [DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
    endtask

    // Writes all four limits on consecutive edges; only called while the
    // pipeline is empty, so the mirror can be updated at once.
    task automatic set_limits(
        input logic signed [DATA_W-1:0] au,
        input logic signed [DATA_W-1:0] al,
        input logic signed [DATA_W-1:0] su,
        input logic signed [DATA_W-1:0] sl
    );
        write_limit(REG_ACCEL_UPPER, au);
        write_limit(REG_ACCEL_LOWER, al);
        write_limit(REG_SPEED_UPPER, su);
        write_limit(REG_SPEED_LOWER, sl);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        accel_upper_q = au;
        accel_lower_q = al;
        speed_upper_q = su;
        speed_lower_q = sl;
    endtask

    // Waits until every queued item has been sent and every command checked.
    // Each item yields one command, so an empty expectation queue means the
    // block is idle. Polling on the falling edge keeps clear of the drivers.
    task automatic drain();
        while (motions_pending.size() != 0 || s_axis_tvalid
                || expected_commands.size() != 0) begin
            @(negedge i_clk);
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Limits straight out of reset are all zero: there is no braking term and
        // the command is the smaller of zero and the current velocity.
        queue_item(S32_MAX, S32_MIN, 32'sh1234_5678, 24'hABCDEF);
        queue_item(32'sd0, 32'sh0001_0000, -32'sd1, 24'd0);
        queue_random(30);
        drain();

        // Ordinary limits: +/-2.0 acceleration, +/-1.5 speed.
        set_limits(32'sh0002_0000, -32'sh0002_0000, 32'sh0001_8000, -32'sh0001_8000);
        queue_item(32'sd0, 32'sd0, 32'sd0, 24'd0);
        // Just inside the deadband on both sides, then right on its edge.
        queue_item(32'sd654, 32'sd0, 32'sd0, 24'h010000);
        queue_item(32'sd0, 32'sd654, 32'sd0, 24'h010000);
        queue_item(32'sd655, 32'sd0, 32'sd0, 24'h010000);
        queue_item(-32'sd655, 32'sd0, 32'sd0, 24'h010000);
        // Distance saturates in both directions.
        queue_item(S32_MAX, S32_MIN, 32'sd0, 24'h028F5C);
        queue_item(S32_MIN, S32_MAX, 32'sd0, 24'h028F5C);
        // Velocity at the rails with the longest time step.
        queue_item(32'sh0010_0000, 32'sh0010_0000, S32_MAX, 24'hFFFFFF);
        queue_item(32'sh0010_0000, 32'sh0010_0000, S32_MIN, 24'hFFFFFF);
        queue_item(-32'sd1, 32'sd0, -32'sd1, 24'hFFFFFF);
        // Far from the goal, then close enough that the braking term drops below the current velocity.
        queue_item(32'sh0005_0000, 32'sd0, 32'sh0001_0000, 24'h040000);
        queue_item(32'sh0000_4000, 32'sd0, 32'sh0001_0000, 24'h010000);
        queue_random(150);
        drain();

        // No braking term at all, and a long run with the pipeline full.
        steady = 1'b1;
        set_limits(32'sd0, -32'sh0000_8000, 32'sh0004_0000, -32'sh0004_0000);
        queue_random(100);
        drain();
        steady = 1'b0;

        // Extreme limits: the doubled braking product reaches 2^63 and its scaled
        // root overflows the output range.
        set_limits(S32_MIN, S32_MAX, S32_MAX, S32_MIN);
        queue_item(S32_MAX, S32_MIN, 32'sd0, 24'd0);
        queue_item(S32_MIN, S32_MAX, 32'sd0, 24'd0);
        queue_item(32'sd0, 32'sd0, S32_MAX, 24'hFFFFFF);
        queue_item(32'sd0, 32'sd0, S32_MIN, 24'hFFFFFF);
        queue_item(32'sd655, 32'sd0, 32'sd0, 24'h000001);
        queue_item(-32'sd656, 32'sd0, 32'sd0, 24'h800000);
        queue_random(120);
        drain();

        // Inverted limits: the floor sits above the ceiling, which must win.
        set_limits(-32'sh0003_0000, 32'sh0001_0000, -32'sh0001_0000, 32'sh0001_0000);
        queue_item(32'sh0004_0000, 32'sd0, 32'sd0, 24'h100000);
        queue_item(-32'sh0004_0000, 32'sd0, 32'sd0, 24'h100000);
        queue_item(32'sd0, 32'sd0, 32'sh0002_0000, 24'h000000);
        queue_item(32'sd100, 32'sd0, -32'sh0002_0000, 24'hFFFFFF);
        queue_random(100);
        drain();

        // Random limit sets.
        repeat (5) begin
            set_limits(random_limit(), random_limit(), random_limit(), random_limit());
            queue_random(90);
            drain();
        end

        // Let any stray command surface before the verdict.
        repeat (24) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("[sqrt_braking_velocity_ramp] OK");
        end else begin
            $display("[sqrt_braking_velocity_ramp] ERROR");
        end
        $finish;
    end

endmodule
